### sv/crsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared types, constants and helper functions of the CRSF RC frame encoder:
// pulse width mapping, channel packing and the frame CRC byte update.
// ----------------------------------------------------------------------------
package crsf_pkg;

	localparam int unsigned US_W      = 16;
	localparam int unsigned CHAN_W    = 11;
	localparam int unsigned NUM_CH    = 8;
	localparam int unsigned NUM_SLOTS = 16;
	localparam int unsigned PACK_W    = NUM_SLOTS * CHAN_W;
	localparam int unsigned FRAME_LEN = 26;
	localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
	localparam int unsigned CFG_W     = 16;

	typedef logic [US_W-1:0]               us_t;
	typedef logic [CHAN_W-1:0]             code_t;
	typedef logic [NUM_CH-1:0][CHAN_W-1:0] codes_t;
	typedef logic [NUM_CH-1:0][US_W-1:0]   widths_t;
	typedef logic [PACK_W-1:0]             pack_t;
	typedef logic [IDX_W-1:0]              byte_idx_t;
	typedef logic [CFG_W-1:0]              cfg_t;

	typedef enum logic {
		REG_TIMEOUT = 1'b0,
		REG_PERIOD  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_CMD  = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	localparam logic [7:0] ADDR_FC     = 8'hC8;
	localparam logic [7:0] PAYLOAD_LEN = 8'd24;
	localparam logic [7:0] TYPE_RC     = 8'h16;
	localparam logic [7:0] CRC_POLY    = 8'hD5;

	localparam byte_idx_t BYTE_ADDR    = byte_idx_t'(0);
	localparam byte_idx_t BYTE_LEN     = byte_idx_t'(1);
	localparam byte_idx_t BYTE_TYPE    = byte_idx_t'(2);
	localparam byte_idx_t BYTE_PAYLOAD = byte_idx_t'(3);
	localparam byte_idx_t BYTE_CRC     = byte_idx_t'(FRAME_LEN - 1);

	localparam us_t   US_LO     = us_t'(988);
	localparam us_t   US_HI     = us_t'(2012);
	localparam code_t CODE_LO   = code_t'(172);
	localparam code_t CODE_HI   = code_t'(1811);
	localparam code_t CODE_MID  = code_t'(992);
	localparam code_t MAP_SLOPE = code_t'(1639);

	localparam cfg_t TIMEOUT_RST = cfg_t'(500);
	localparam cfg_t PERIOD_RST  = cfg_t'(20);
	localparam us_t  COUNT_MAX   = '1;

	localparam codes_t DEFAULT_CODES = {
		CODE_LO, CODE_LO, CODE_LO, CODE_LO, CODE_MID, CODE_LO, CODE_MID, CODE_MID
	};

	// widths below 988 and above 2012 saturate, so the 800..2200 clamp folds away
	function automatic code_t width_to_code(input us_t w);
		logic [9:0]  d;
		logic [20:0] p;
		logic [20:0] r;
		code_t       c;
		d = 10'(w - US_LO);
		p = 21'(d) * 21'(MAP_SLOPE);
		r = p + 21'd512;
		if (w <= US_LO) begin
			c = CODE_LO;
		end else if (w >= US_HI) begin
			c = CODE_HI;
		end else begin
			c = CODE_LO + r[20:10];
		end
		return c;
	endfunction

	function automatic logic [7:0] crc_update(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] x;
		x = c ^ b;
		for (int j = 0; j < 8; j++) begin
			x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
		end
		return x;
	endfunction

	// channels packed lsb first, upper eight slots fixed at the center code
	function automatic pack_t pack_channels(input codes_t ch);
		pack_t p;
		p = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			p[i*CHAN_W +: CHAN_W] = (i < NUM_CH) ? ch[i] : CODE_MID;
		end
		return p;
	endfunction

endpackage

### sv/crsf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_if
// Handshake channels of the CRSF RC frame encoder: the command / tick item
// channel and the frame byte channel.
// ----------------------------------------------------------------------------
interface crsf_item_if import crsf_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  kind;
	us_t   aileron_us;
	us_t   elevator_us;
	us_t   throttle_us;
	us_t   rudder_us;
	us_t   aux_one_us;
	us_t   aux_two_us;
	us_t   aux_three_us;
	us_t   aux_four_us;

	modport source (
		output valid, kind, aileron_us, elevator_us, throttle_us, rudder_us,
		       aux_one_us, aux_two_us, aux_three_us, aux_four_us,
		input  ready
	);
	modport sink (
		input  valid, kind, aileron_us, elevator_us, throttle_us, rudder_us,
		       aux_one_us, aux_two_us, aux_three_us, aux_four_us,
		output ready
	);
endinterface

interface crsf_byte_if ();
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

### sv/crsf_rc_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_rc_frame_encoder_unit
// Maps eight pulse widths to CRSF channel codes and emits RC channel frames
// on millisecond ticks, with command timeout and fixed upper channels.
// ----------------------------------------------------------------------------
// An item (command or tick) can be taken into the input register every cycle
// unless a tick is held there, and is applied to the channel state from that
// register. A tick that fires a frame snapshots the packed channels into the
// byte serializer, which sends the 26 frame bytes at one byte per cycle while
// the output is not stalled and updates the CRC byte by byte. A tick that fires a
// frame while the serializer still holds the previous one waits in the input
// register until the serializer has moved that frame's CRC byte into its
// output register.
module crsf_rc_frame_encoder_unit import crsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	crsf_item_if.sink   item,
	crsf_byte_if.source frame,
	input  logic        write_en,
	input  reg_idx_t    reg_index,
	input  cfg_t        write_data
);

	// input register
	logic      valid_s1;
	logic      kind_s1;
	widths_t   us_s1;

	// channel state and settings
	codes_t    chan_q;
	logic      seen_q;
	us_t       since_cmd_q;
	us_t       since_frame_q;
	cfg_t      timeout_q;
	cfg_t      period_q;

	// serializer
	logic      busy_q;
	byte_idx_t idx_q;
	logic [7:0] crc_q;
	pack_t     pack_q;
	logic      out_valid_q;
	logic [7:0] out_byte_q;
	logic      out_last_q;

	codes_t    cmd_codes;
	codes_t    tick_codes;
	us_t       cmd_inc;
	us_t       frame_inc;
	logic      expired;
	logic      fire;
	logic      is_tick;
	logic      consume;
	logic      load;
	logic      step;
	byte_idx_t pay_idx;
	logic [7:0] cur_byte;
	logic [7:0] crc_next;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			cmd_codes[i] = width_to_code(us_s1[i]);
		end
	end

	assign cmd_inc    = (since_cmd_q == COUNT_MAX) ? since_cmd_q : since_cmd_q + 1'b1;
	assign frame_inc  = (since_frame_q == COUNT_MAX) ? since_frame_q : since_frame_q + 1'b1;
	assign expired    = !seen_q || (cmd_inc > timeout_q);
	assign fire       = frame_inc >= period_q;
	assign tick_codes = expired ? DEFAULT_CODES : chan_q;
	assign is_tick    = (kind_s1 == KIND_TICK);
	assign consume    = valid_s1 && !(is_tick && fire && busy_q);
	assign load       = valid_s1 && is_tick && fire && !busy_q;
	assign item.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1  <= item.kind;
			us_s1[0] <= item.aileron_us;
			us_s1[1] <= item.elevator_us;
			us_s1[2] <= item.throttle_us;
			us_s1[3] <= item.rudder_us;
			us_s1[4] <= item.aux_one_us;
			us_s1[5] <= item.aux_two_us;
			us_s1[6] <= item.aux_three_us;
			us_s1[7] <= item.aux_four_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			period_q  <= PERIOD_RST;
		end else if (write_en) begin
			unique case (reg_index)
				REG_TIMEOUT: timeout_q <= write_data;
				REG_PERIOD:  period_q  <= write_data;
				default:     timeout_q <= timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q        <= DEFAULT_CODES;
			seen_q        <= 1'b0;
			since_cmd_q   <= '0;
			since_frame_q <= '0;
		end else if (consume) begin
			if (is_tick) begin
				chan_q        <= tick_codes;
				since_cmd_q   <= cmd_inc;
				since_frame_q <= fire ? '0 : frame_inc;
			end else begin
				chan_q      <= cmd_codes;
				seen_q      <= 1'b1;
				since_cmd_q <= '0;
			end
		end
	end

	// byte serializer
	assign step    = busy_q && (!out_valid_q || frame.ready);
	assign pay_idx = idx_q - BYTE_PAYLOAD;

	always_comb begin
		unique case (idx_q)
			BYTE_ADDR: cur_byte = ADDR_FC;
			BYTE_LEN:  cur_byte = PAYLOAD_LEN;
			BYTE_TYPE: cur_byte = TYPE_RC;
			BYTE_CRC:  cur_byte = crc_q;
			default:   cur_byte = pack_q[{pay_idx, 3'b000} +: 8];
		endcase
		crc_next = ((idx_q >= BYTE_TYPE) && (idx_q != BYTE_CRC)) ?
			crc_update(crc_q, cur_byte) : crc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= BYTE_ADDR;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= BYTE_ADDR;
				crc_q  <= '0;
			end else if (step) begin
				crc_q <= crc_next;
				if (idx_q == BYTE_CRC) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (idx_q == BYTE_CRC);
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pack_q <= pack_channels(tick_codes);
		end
		if (step) begin
			out_byte_q <= cur_byte;
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.last_byte  = out_last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= BYTE_CRC)
		else $error("serializer index past crc byte");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == BYTE_ADDR && crc_q == '0)
		else $error("frame load did not restart serializer");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !consume) |-> busy_q)
		else $error("input stalled with idle serializer");

	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(step && idx_q == BYTE_ADDR) |=> frame.frame_byte == ADDR_FC && !frame.last_byte)
		else $error("frame does not open with address byte");

	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(step && idx_q == BYTE_CRC) |=> frame.valid && frame.last_byte && !busy_q)
		else $error("crc byte not marked last");

endmodule

### tb/sv/tb_crsf_rc_frame_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crsf_rc_frame_encoder_unit
// Drives commands and millisecond ticks into the CRSF RC frame encoder and
// checks every frame byte it sends against frames built here from the channel
// state: reset settings, pulse width mapping at its edges, short and extreme
// timeout and period values, full-scale settings, a long output stall and
// random phases with idling on both channels.
// ----------------------------------------------------------------------------
module tb_crsf_rc_frame_encoder_unit;
	import crsf_pkg::*;

	localparam int unsigned CLAMP_LO_US   = 800;
	localparam int unsigned CLAMP_HI_US   = 2200;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		kind_t   kind;
		widths_t widths;
	} rc_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     write_en;
	reg_idx_t reg_index;
	cfg_t     write_data;

	crsf_item_if item_ch ();
	crsf_byte_if frame_ch ();

	crsf_rc_frame_encoder_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.frame      (frame_ch),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// channel state tracked alongside the block
	code_t       chan_code [NUM_CH];
	logic        cmd_seen;
	logic [15:0] ms_cmd;
	logic [15:0] ms_frame;
	cfg_t        timeout_cfg;
	cfg_t        period_cfg;

	frame_byte_t frame_bytes_q [$];

	bit idle_on;
	int hold_requests;
	int err_count;
	int items_sent;
	int frames_built;
	int bytes_checked;
	int cycle_count = 0;

	function automatic code_t pulse_code(input us_t w);
		int unsigned v;
		v = w;
		if (v < CLAMP_LO_US) v = CLAMP_LO_US;
		if (v > CLAMP_HI_US) v = CLAMP_HI_US;
		if (v <= US_LO) return CODE_LO;
		if (v >= US_HI) return CODE_HI;
		return code_t'(CODE_LO + (((v - US_LO) * MAP_SLOPE + 512) >> 10));
	endfunction

	function automatic void restore_defaults();
		for (int i = 0; i < NUM_CH; i++) begin
			chan_code[i] = (i == 2 || i >= 4) ? CODE_LO : CODE_MID;
		end
	endfunction

	function automatic void build_frame();
		pack_t       slots;
		logic [7:0]  fb [FRAME_LEN];
		logic [7:0]  crc;
		frame_byte_t e;
		slots = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (i < NUM_CH) begin
				slots[i*CHAN_W +: CHAN_W] = chan_code[i];
			end else begin
				slots[i*CHAN_W +: CHAN_W] = CODE_MID;
			end
		end
		fb[0] = ADDR_FC;
		fb[1] = PAYLOAD_LEN;
		fb[2] = TYPE_RC;
		for (int k = 0; k < PACK_W / 8; k++) begin
			fb[3 + k] = slots[8*k +: 8];
		end
		crc = 8'h00;
		for (int i = 2; i < FRAME_LEN - 1; i++) begin
			crc = crc ^ fb[i];
			for (int j = 0; j < 8; j++) begin
				crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
			end
		end
		fb[FRAME_LEN - 1] = crc;
		for (int i = 0; i < FRAME_LEN; i++) begin
			e.value = fb[i];
			e.last  = (i == FRAME_LEN - 1);
			frame_bytes_q.push_back(e);
		end
		frames_built++;
	endfunction

	function automatic void apply_item(input rc_item_t it);
		if (it.kind == KIND_CMD) begin
			for (int i = 0; i < NUM_CH; i++) begin
				chan_code[i] = pulse_code(it.widths[i]);
			end
			cmd_seen = 1'b1;
			ms_cmd   = '0;
		end else begin
			if (ms_cmd != 16'hFFFF) ms_cmd++;
			if (ms_frame != 16'hFFFF) ms_frame++;
			if (!cmd_seen || ms_cmd > timeout_cfg) restore_defaults();
			if (ms_frame >= period_cfg) begin
				ms_frame = '0;
				build_frame();
			end
		end
	endfunction

	function automatic us_t boundary_pulse();
		case ($urandom_range(0, 14))
			0:       return us_t'(0);
			1:       return us_t'(799);
			2:       return us_t'(800);
			3:       return us_t'(801);
			4:       return us_t'(987);
			5:       return us_t'(988);
			6:       return us_t'(989);
			7:       return us_t'(1500);
			8:       return us_t'(2011);
			9:       return us_t'(2012);
			10:      return us_t'(2013);
			11:      return us_t'(2199);
			12:      return us_t'(2200);
			13:      return us_t'(2201);
			default: return us_t'(16'hFFFF);
		endcase
	endfunction

	function automatic us_t rand_pulse();
		case ($urandom_range(0, 3))
			0:       return us_t'($urandom_range(0, 65535));
			1:       return us_t'($urandom_range(700, 2300));
			2:       return us_t'($urandom_range(988, 2012));
			default: return boundary_pulse();
		endcase
	endfunction

	function automatic rc_item_t make_tick();
		rc_item_t it;
		it.kind = KIND_TICK;
		for (int i = 0; i < NUM_CH; i++) begin
			it.widths[i] = us_t'($urandom_range(0, 65535));
		end
		return it;
	endfunction

	function automatic rc_item_t make_cmd(input widths_t w);
		rc_item_t it;
		it.kind   = KIND_CMD;
		it.widths = w;
		return it;
	endfunction

	function automatic widths_t rand_widths();
		widths_t w;
		for (int i = 0; i < NUM_CH; i++) begin
			w[i] = rand_pulse();
		end
		return w;
	endfunction

	function automatic widths_t widths8(input us_t a, input us_t b, input us_t c, input us_t d,
			input us_t e, input us_t f, input us_t g, input us_t h);
		widths_t w;
		w[0] = a; w[1] = b; w[2] = c; w[3] = d;
		w[4] = e; w[5] = f; w[6] = g; w[7] = h;
		return w;
	endfunction

	task automatic send_item(input rc_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.kind         <= it.kind;
		item_ch.aileron_us   <= it.widths[0];
		item_ch.elevator_us  <= it.widths[1];
		item_ch.throttle_us  <= it.widths[2];
		item_ch.rudder_us    <= it.widths[3];
		item_ch.aux_one_us   <= it.widths[4];
		item_ch.aux_two_us   <= it.widths[5];
		item_ch.aux_three_us <= it.widths[6];
		item_ch.aux_four_us  <= it.widths[7];
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		apply_item(it);
		items_sent++;
	endtask

	// drop valid, drain all pending frames, then let the input register empty
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (frame_bytes_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input cfg_t to, input cfg_t per);
		settle();
		write_en   <= 1'b1;
		reg_index  <= REG_TIMEOUT;
		write_data <= to;
		@(posedge clk);
		reg_index  <= REG_PERIOD;
		write_data <= per;
		@(posedge clk);
		write_en    <= 1'b0;
		timeout_cfg = to;
		period_cfg  = per;
	endtask

	task automatic test_reset_config();
		idle_on = 1'b1;
		repeat (20) send_item(make_tick());
	endtask

	task automatic test_pulse_mapping();
		configure(16'hFFFF, 16'd1);
		send_item(make_cmd(widths8(0, 0, 0, 0, 0, 0, 0, 0)));
		send_item(make_tick());
		send_item(make_cmd(widths8(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)));
		send_item(make_tick());
		send_item(make_cmd(widths8(799, 800, 801, 987, 988, 989, 990, 1500)));
		send_item(make_tick());
		send_item(make_cmd(widths8(2011, 2012, 2013, 2199, 2200, 2201, 1000, 2000)));
		send_item(make_tick());
	endtask

	task automatic test_short_limits();
		configure(16'd0, 16'd0);
		send_item(make_cmd(widths8(1100, 1200, 1300, 1400, 1600, 1700, 1800, 1900)));
		repeat (3) send_item(make_tick());
		configure(16'd1, 16'd1);
		send_item(make_cmd(rand_widths()));
		repeat (3) send_item(make_tick());
	endtask

	// largest timeout and period, then the largest and next-largest timeout with a short period
	task automatic test_full_scale();
		idle_on = 1'b0;
		configure(16'hFFFF, 16'hFFFF);
		send_item(make_cmd(widths8(1234, 1111, 1999, 1001, 1500, 1750, 1250, 2100)));
		repeat (4) send_item(make_tick());
		configure(16'hFFFF, 16'd1);
		repeat (2) send_item(make_tick());
		configure(16'hFFFE, 16'd1);
		send_item(make_tick());
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		configure(cfg_t'($urandom_range(2, 20)), 16'd1);
		hold_requests++;
		repeat (40) begin
			if ($urandom_range(0, 3) == 0) send_item(make_cmd(rand_widths()));
			else send_item(make_tick());
		end
		idle_on = 1'b1;
	endtask

	task automatic run_random_phase(input int n);
		cfg_t to;
		cfg_t per;
		case ($urandom_range(0, 5))
			0:       to = 16'd0;
			1:       to = 16'd1;
			2, 3:    to = cfg_t'($urandom_range(2, 30));
			4:       to = 16'hFFFF;
			default: to = cfg_t'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 4))
			0:       per = 16'd0;
			1:       per = 16'd1;
			default: per = cfg_t'($urandom_range(2, 8));
		endcase
		configure(to, per);
		repeat (n) begin
			if ($urandom_range(0, 99) < 35) send_item(make_cmd(rand_widths()));
			else send_item(make_tick());
		end
	endtask

	task automatic test_random();
		idle_on = 1'b1;
		repeat (6) run_random_phase(28);
		idle_on = 1'b0;
		repeat (2) run_random_phase(28);
	endtask

	initial begin : byte_sink
		int stall_left;
		int served;
		stall_left = 0;
		served     = 0;
		frame_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served     = hold_requests;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14);
			end
			if (stall_left > 0) begin
				frame_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				frame_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : byte_check
		frame_byte_t want;
		if (arst_n && frame_ch.valid && frame_ch.ready) begin
			if (frame_bytes_q.size() == 0) begin
				$error("unexpected frame byte %h", frame_ch.frame_byte);
				err_count++;
			end else begin
				want = frame_bytes_q.pop_front();
				bytes_checked++;
				if (frame_ch.frame_byte !== want.value) begin
					$error("frame_byte mismatch: expected %h, actual %h",
						want.value, frame_ch.frame_byte);
					err_count++;
				end
				if (frame_ch.last_byte !== want.last) begin
					$error("last_byte mismatch: expected %b, actual %b",
						want.last, frame_ch.last_byte);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL crsf_rc_frame_encoder_unit");
			$finish;
		end
	end

	initial begin
		arst_n               <= 1'b0;
		write_en             <= 1'b0;
		reg_index            <= REG_TIMEOUT;
		write_data           <= '0;
		item_ch.valid        <= 1'b0;
		item_ch.kind         <= KIND_TICK;
		item_ch.aileron_us   <= '0;
		item_ch.elevator_us  <= '0;
		item_ch.throttle_us  <= '0;
		item_ch.rudder_us    <= '0;
		item_ch.aux_one_us   <= '0;
		item_ch.aux_two_us   <= '0;
		item_ch.aux_three_us <= '0;
		item_ch.aux_four_us  <= '0;
		restore_defaults();
		cmd_seen      = 1'b0;
		ms_cmd        = '0;
		ms_frame      = '0;
		timeout_cfg   = TIMEOUT_RST;
		period_cfg    = PERIOD_RST;
		idle_on       = 1'b1;
		hold_requests = 0;
		err_count     = 0;
		items_sent    = 0;
		frames_built  = 0;
		bytes_checked = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_pulse_mapping();
		test_short_limits();
		test_full_scale();
		test_backpressure();
		test_random();

		settle();
		repeat (16) @(posedge clk);
		$display("covered %0d commands and ticks, %0d frames, %0d frame bytes checked",
			items_sent, frames_built, bytes_checked);
		$display("settings ran from zero to full-scale timeout and period, with output stalls");
		if (err_count == 0 && frame_bytes_q.size() == 0) begin
			$display("PASS crsf_rc_frame_encoder_unit");
		end else begin
			$display("FAIL crsf_rc_frame_encoder_unit");
		end
		$finish;
	end

endmodule
